// ----- rtl/rdbr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdbr_pkg
// Shared widths, types and register codes of the radial distortion remap.
// ----------------------------------------------------------------------------
package rdbr_pkg;

   localparam int FRAC_BITS      = 12;
   localparam int COL_BITS       = 10;
   localparam int ROW_BITS       = 10;
   localparam int PIX_BITS       = 16;
   localparam int DIM_BITS       = 11;
   localparam int CENTRE_BITS    = 24;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 2 * CENTRE_BITS;
   localparam int COEF_BITS      = 32;
   localparam int NUM_COEFS      = 5;
   localparam int DELTA_BITS     = 26;
   localparam int RAD_BITS       = 50;
   localparam int ROOT_BITS      = 25;
   localparam int REM_BITS       = ROOT_BITS + 1;
   localparam int SQ_STEPS       = ROOT_BITS;
   localparam int S_SHIFT        = 17 - FRAC_BITS;
   localparam int S_BITS         = ROOT_BITS + S_SHIFT;
   localparam int HORNER_STEPS   = 4;
   localparam int HPROD_BITS     = COEF_BITS + S_BITS + 1;
   localparam int QSHIFT         = 28;
   localparam int MPROD_BITS     = DELTA_BITS + COEF_BITS;
   localparam int POS_BITS       = 33;
   localparam int CELL_BITS      = POS_BITS - FRAC_BITS;
   localparam int BANK_ADDR_BITS = COL_BITS - 1 + ROW_BITS - 1;
   localparam int NUM_BANKS      = 4;
   localparam int WEIGHT_BITS    = FRAC_BITS + 1;
   localparam int H_BITS         = PIX_BITS + WEIGHT_BITS;
   localparam int T_BITS         = H_BITS + WEIGHT_BITS;
   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int CLAMP_MAX      = 65535;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH   = 4'd0,
      REG_FRAME_HEIGHT  = 4'd1,
      REG_OPTICAL_CTR   = 4'd2,
      REG_COEFF_CONST   = 4'd3,
      REG_COEFF_LIN     = 4'd4,
      REG_COEFF_QUAD    = 4'd5,
      REG_COEFF_CUBIC   = 4'd6,
      REG_COEFF_QUARTIC = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic                         wr;
      logic [COL_BITS-1:0]          col;
      logic [ROW_BITS-1:0]          row;
      logic [PIX_BITS-1:0]          pix;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
   } ctx_type;

endpackage
`default_nettype wire

// ----- rtl/rdbr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdbr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rdbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/radial_distortion_bilinear_remap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radial_distortion_bilinear_remap
// Radial lens distortion correction with bilinear resampling of 16-bit pixels.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_type, req_col, req_row, req_pixel_in
//   rsp      out  rsp_valid/rsp_stall   rsp_out_value, rsp_outside
//   csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One item per cycle; a compute item gives its result through the 25-stage
// square root, the 8-stage Horner chain and the four-bank frame store read.
// Write items store their pixel at the read stage and give no result. Reset
// clears the valid bits and loads the register defaults; the frame store is
// not cleared. A held result stalls the pipeline.
// ----------------------------------------------------------------------------
module radial_distortion_bilinear_remap (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [rdbr_pkg::COL_BITS-1:0]       req_col,
   input  wire logic [rdbr_pkg::ROW_BITS-1:0]       req_row,
   input  wire logic [rdbr_pkg::PIX_BITS-1:0]       req_pixel_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [rdbr_pkg::PIX_BITS-1:0]       rsp_out_value,
   output logic                                     rsp_outside,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rdbr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rdbr_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rdbr_pkg::*;

   function automatic logic signed [COEF_BITS-1:0] sat32(input logic signed [COEF_BITS+3:0] v);
      logic signed [COEF_BITS-1:0] r;
      if (v > $signed({4'b0, 1'b0, {(COEF_BITS-1){1'b1}}})) begin
         r = {1'b0, {(COEF_BITS-1){1'b1}}};
      end else if (v < $signed({4'b1111, 1'b1, {(COEF_BITS-1){1'b0}}})) begin
         r = {1'b1, {(COEF_BITS-1){1'b0}}};
      end else begin
         r = v[COEF_BITS-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [DIM_BITS-1:0]          frame_width_ff, frame_height_ff;
   logic [CSR_DATA_BITS-1:0]     centre_ff;
   logic signed [COEF_BITS-1:0]  coeff_ff [NUM_COEFS];
   logic [CENTRE_BITS-1:0]       cx, cy;
   logic [DIM_BITS-1:0]          w_eff, h_eff;

   assign csr_ready = 1'b1;
   assign cx = centre_ff[CENTRE_BITS-1:0];
   assign cy = centre_ff[CSR_DATA_BITS-1:CENTRE_BITS];
   assign w_eff = (frame_width_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH)
                                                          : frame_width_ff;
   assign h_eff = (frame_height_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT)
                                                            : frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_BITS'(1024);
         frame_height_ff <= DIM_BITS'(1024);
         centre_ff       <= CSR_DATA_BITS'(48'd35184374185984);
         coeff_ff[0]     <= 32'sd268435456;
         coeff_ff[1]     <= '0;
         coeff_ff[2]     <= '0;
         coeff_ff[3]     <= '0;
         coeff_ff[4]     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:   frame_width_ff  <= csr_data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff <= csr_data[DIM_BITS-1:0];
            REG_OPTICAL_CTR:   centre_ff       <= csr_data;
            REG_COEFF_CONST:   coeff_ff[0]     <= csr_data[COEF_BITS-1:0];
            REG_COEFF_LIN:     coeff_ff[1]     <= csr_data[COEF_BITS-1:0];
            REG_COEFF_QUAD:    coeff_ff[2]     <= csr_data[COEF_BITS-1:0];
            REG_COEFF_CUBIC:   coeff_ff[3]     <= csr_data[COEF_BITS-1:0];
            REG_COEFF_QUARTIC: coeff_ff[4]     <= csr_data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic en;
   logic out_v_ff;

   assign en        = !(out_v_ff && rsp_stall);
   assign req_stall = !en;

   // stage 0: offsets from the centre
   ctx_type s0_ctx_ff, s0_ctx_in;
   logic    s0_v_ff;

   always_comb begin
      s0_ctx_in.wr  = !req_type;
      s0_ctx_in.col = req_col;
      s0_ctx_in.row = req_row;
      s0_ctx_in.pix = req_pixel_in;
      s0_ctx_in.dx  = $signed({4'b0, req_col, {FRAC_BITS{1'b0}}}) - $signed({2'b0, cx});
      s0_ctx_in.dy  = $signed({4'b0, req_row, {FRAC_BITS{1'b0}}}) - $signed({2'b0, cy});
   end

   // stage 1: squares, stage 2: sum
   ctx_type                    s1_ctx_ff, s2_ctx_ff;
   logic                       s1_v_ff, s2_v_ff;
   logic [RAD_BITS-1:0]        s1_dxx_ff, s1_dyy_ff, s2_rad_ff;
   logic signed [2*DELTA_BITS-1:0] dxx_full, dyy_full;

   assign dxx_full = s0_ctx_ff.dx * s0_ctx_ff.dx;
   assign dyy_full = s0_ctx_ff.dy * s0_ctx_ff.dy;

   // square root, one result bit per stage
   logic [REM_BITS-1:0]  sq_rem_ff  [SQ_STEPS];
   logic [ROOT_BITS-1:0] sq_root_ff [SQ_STEPS];
   logic [RAD_BITS-1:0]  sq_rad_ff  [SQ_STEPS];
   ctx_type              sq_ctx_ff  [SQ_STEPS];
   logic [SQ_STEPS-1:0]  sq_v_ff;
   logic [REM_BITS-1:0]  sq_rem_in  [SQ_STEPS];
   logic [ROOT_BITS-1:0] sq_root_in [SQ_STEPS];
   logic [RAD_BITS-1:0]  sq_rad_in  [SQ_STEPS];
   ctx_type              sq_ctx_in  [SQ_STEPS];
   logic [SQ_STEPS-1:0]  sq_v_in;

   always_comb begin
      logic [REM_BITS-1:0]  rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [RAD_BITS-1:0]  rad_src;
      logic [REM_BITS+1:0]  remx, trial;
      for (int j = 0; j < SQ_STEPS; j++) begin
         if (j == 0) begin
            rem_src      = '0;
            root_src     = '0;
            rad_src      = s2_rad_ff;
            sq_ctx_in[j] = s2_ctx_ff;
            sq_v_in[j]   = s2_v_ff;
         end else begin
            rem_src      = sq_rem_ff[j-1];
            root_src     = sq_root_ff[j-1];
            rad_src      = sq_rad_ff[j-1];
            sq_ctx_in[j] = sq_ctx_ff[j-1];
            sq_v_in[j]   = sq_v_ff[j-1];
         end
         remx  = {rem_src, rad_src[RAD_BITS-1:RAD_BITS-2]};
         trial = {1'b0, root_src, 2'b01};
         if (remx >= trial) begin
            sq_rem_in[j]  = REM_BITS'(remx - trial);
            sq_root_in[j] = {root_src[ROOT_BITS-2:0], 1'b1};
         end else begin
            sq_rem_in[j]  = remx[REM_BITS-1:0];
            sq_root_in[j] = {root_src[ROOT_BITS-2:0], 1'b0};
         end
         sq_rad_in[j] = {rad_src[RAD_BITS-3:0], 2'b00};
      end
   end

   // Horner chain: multiply stage then shift, add and saturate stage
   logic signed [HPROD_BITS-1:0] hm_prod_ff [HORNER_STEPS];
   logic [S_BITS-1:0]            hm_s_ff    [HORNER_STEPS];
   ctx_type                      hm_ctx_ff  [HORNER_STEPS];
   logic [HORNER_STEPS-1:0]      hm_v_ff;
   logic signed [COEF_BITS-1:0]  ha_acc_ff  [HORNER_STEPS];
   logic [S_BITS-1:0]            ha_s_ff    [HORNER_STEPS];
   ctx_type                      ha_ctx_ff  [HORNER_STEPS];
   logic [HORNER_STEPS-1:0]      ha_v_ff;
   logic signed [HPROD_BITS-1:0] hm_prod_in [HORNER_STEPS];
   logic [S_BITS-1:0]            hm_s_in    [HORNER_STEPS];
   ctx_type                      hm_ctx_in  [HORNER_STEPS];
   logic [HORNER_STEPS-1:0]      hm_v_in;
   logic signed [COEF_BITS-1:0]  ha_acc_in  [HORNER_STEPS];

   always_comb begin
      logic signed [COEF_BITS-1:0] acc_src;
      logic signed [COEF_BITS+3:0] sum;
      for (int k = 0; k < HORNER_STEPS; k++) begin
         if (k == 0) begin
            acc_src      = coeff_ff[NUM_COEFS-1];
            hm_s_in[k]   = {sq_root_ff[SQ_STEPS-1], {S_SHIFT{1'b0}}};
            hm_ctx_in[k] = sq_ctx_ff[SQ_STEPS-1];
            hm_v_in[k]   = sq_v_ff[SQ_STEPS-1];
         end else begin
            acc_src      = ha_acc_ff[k-1];
            hm_s_in[k]   = ha_s_ff[k-1];
            hm_ctx_in[k] = ha_ctx_ff[k-1];
            hm_v_in[k]   = ha_v_ff[k-1];
         end
         hm_prod_in[k] = acc_src * $signed({1'b0, hm_s_in[k]});
         sum = $signed(hm_prod_ff[k][HPROD_BITS-1:QSHIFT])
             + $signed({{4{coeff_ff[HORNER_STEPS-1-k][COEF_BITS-1]}},
                        coeff_ff[HORNER_STEPS-1-k]});
         ha_acc_in[k] = sat32(sum);
      end
   end

   // source position
   logic signed [MPROD_BITS-1:0] mp_px_ff, mp_py_ff;
   ctx_type                      mp_ctx_ff, xp_ctx_ff;
   logic                         mp_v_ff, xp_v_ff;
   logic signed [POS_BITS-1:0]   xp_x_ff, xp_y_ff, xp_x_in, xp_y_in;

   assign xp_x_in = $signed({{(POS_BITS-CENTRE_BITS){1'b0}}, cx})
                  + POS_BITS'($signed(mp_px_ff[MPROD_BITS-1:QSHIFT]));
   assign xp_y_in = $signed({{(POS_BITS-CENTRE_BITS){1'b0}}, cy})
                  + POS_BITS'($signed(mp_py_ff[MPROD_BITS-1:QSHIFT]));

   // bounds and bank addressing
   logic signed [CELL_BITS-1:0]  left, down;
   logic signed [CELL_BITS:0]    left1, down1;
   logic                         bd_out_in;
   logic [BANK_ADDR_BITS-1:0]    bd_addr_in [NUM_BANKS];
   logic [BANK_ADDR_BITS-1:0]    bd_addr_ff [NUM_BANKS];
   logic                         bd_out_ff, bd_l0_ff, bd_d0_ff, bd_v_ff;
   logic [FRAC_BITS-1:0]         bd_fx_ff, bd_fy_ff;
   ctx_type                      bd_ctx_ff;

   assign left  = xp_x_ff[POS_BITS-1:FRAC_BITS];
   assign down  = xp_y_ff[POS_BITS-1:FRAC_BITS];
   assign left1 = {left[CELL_BITS-1], left} + (CELL_BITS+1)'(1);
   assign down1 = {down[CELL_BITS-1], down} + (CELL_BITS+1)'(1);
   assign bd_out_in = left[CELL_BITS-1] || down[CELL_BITS-1]
                   || (left1 >= $signed({{(CELL_BITS+1-DIM_BITS){1'b0}}, w_eff}))
                   || (down1 >= $signed({{(CELL_BITS+1-DIM_BITS){1'b0}}, h_eff}));

   always_comb begin
      logic [COL_BITS-1:0] csel;
      logic [ROW_BITS-1:0] rsel;
      for (int b = 0; b < NUM_BANKS; b++) begin
         csel = (left[0] == b[0]) ? left[COL_BITS-1:0] : left1[COL_BITS-1:0];
         rsel = (down[0] == b[1]) ? down[ROW_BITS-1:0] : down1[ROW_BITS-1:0];
         bd_addr_in[b] = {rsel[ROW_BITS-1:1], csel[COL_BITS-1:1]};
      end
   end

   // frame store, four banks by row and column parity
   logic [PIX_BITS-1:0]       rd_dat [NUM_BANKS];
   logic [NUM_BANKS-1:0]      bank_we;
   logic [BANK_ADDR_BITS-1:0] bank_waddr;

   assign bank_waddr = {bd_ctx_ff.row[ROW_BITS-1:1], bd_ctx_ff.col[COL_BITS-1:1]};

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      assign bank_we[b] = en && bd_v_ff && bd_ctx_ff.wr
                       && (bd_ctx_ff.row[0] == b[1]) && (bd_ctx_ff.col[0] == b[0]);
      rdbr_ram #(
         .WIDTH (PIX_BITS),
         .DEPTH (1 << BANK_ADDR_BITS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_waddr),
         .wr_data (bd_ctx_ff.pix),
         .rd_en   (en),
         .rd_addr (bd_addr_ff[b]),
         .rd_data (rd_dat[b])
      );
   end

   // read stage and interpolation
   logic                   rd_v_ff, rd_wr_ff, rd_out_ff, rd_l0_ff, rd_d0_ff;
   logic [FRAC_BITS-1:0]   rd_fx_ff, rd_fy_ff;
   logic [PIX_BITS-1:0]    p00, p01, p10, p11;
   logic [WEIGHT_BITS-1:0] wfx0, wfx1, wfy0, wfy1;
   logic [H_BITS-1:0]      i1_h0_ff, i1_h1_ff;
   logic [FRAC_BITS-1:0]   i1_fy_ff;
   logic                   i1_out_ff, i1_v_ff;
   logic [T_BITS-1:0]      i2_t0_ff, i2_t1_ff;
   logic                   i2_out_ff, i2_v_ff;
   logic [T_BITS:0]        total;
   logic [T_BITS-2*FRAC_BITS:0] hi;
   logic [PIX_BITS-1:0]    val;

   assign p00  = rd_dat[{rd_d0_ff, rd_l0_ff}];
   assign p01  = rd_dat[{rd_d0_ff, !rd_l0_ff}];
   assign p10  = rd_dat[{!rd_d0_ff, rd_l0_ff}];
   assign p11  = rd_dat[{!rd_d0_ff, !rd_l0_ff}];
   assign wfx1 = {1'b0, rd_fx_ff};
   assign wfx0 = (WEIGHT_BITS)'(1 << FRAC_BITS) - wfx1;
   assign wfy1 = {1'b0, i1_fy_ff};
   assign wfy0 = (WEIGHT_BITS)'(1 << FRAC_BITS) - wfy1;
   assign total = {1'b0, i2_t0_ff} + {1'b0, i2_t1_ff};
   assign hi    = total[T_BITS:2*FRAC_BITS];
   assign val   = (hi > ($bits(hi))'(CLAMP_MAX)) ? PIX_BITS'(CLAMP_MAX) : hi[PIX_BITS-1:0];

   logic [PIX_BITS-1:0] out_value_ff;
   logic                out_outside_ff;

   assign rsp_valid     = out_v_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_outside   = out_outside_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         sq_v_ff  <= '0;
         hm_v_ff  <= '0;
         ha_v_ff  <= '0;
         mp_v_ff  <= 1'b0;
         xp_v_ff  <= 1'b0;
         bd_v_ff  <= 1'b0;
         rd_v_ff  <= 1'b0;
         i1_v_ff  <= 1'b0;
         i2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff  <= req_valid;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         sq_v_ff  <= sq_v_in;
         hm_v_ff  <= hm_v_in;
         ha_v_ff  <= hm_v_ff;
         mp_v_ff  <= ha_v_ff[HORNER_STEPS-1];
         xp_v_ff  <= mp_v_ff;
         bd_v_ff  <= xp_v_ff;
         rd_v_ff  <= bd_v_ff;
         i1_v_ff  <= rd_v_ff && !rd_wr_ff;
         i2_v_ff  <= i1_v_ff;
         out_v_ff <= i2_v_ff;
      end
   end

   // payload, advance on enable, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ctx_ff <= s0_ctx_in;
         s1_ctx_ff <= s0_ctx_ff;
         s1_dxx_ff <= dxx_full[RAD_BITS-1:0];
         s1_dyy_ff <= dyy_full[RAD_BITS-1:0];
         s2_ctx_ff <= s1_ctx_ff;
         s2_rad_ff <= s1_dxx_ff + s1_dyy_ff;
         for (int j = 0; j < SQ_STEPS; j++) begin
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_rad_ff[j]  <= sq_rad_in[j];
            sq_ctx_ff[j]  <= sq_ctx_in[j];
         end
         for (int k = 0; k < HORNER_STEPS; k++) begin
            hm_prod_ff[k] <= hm_prod_in[k];
            hm_s_ff[k]    <= hm_s_in[k];
            hm_ctx_ff[k]  <= hm_ctx_in[k];
            ha_acc_ff[k]  <= ha_acc_in[k];
            ha_s_ff[k]    <= hm_s_ff[k];
            ha_ctx_ff[k]  <= hm_ctx_ff[k];
         end
         mp_ctx_ff <= ha_ctx_ff[HORNER_STEPS-1];
         mp_px_ff  <= ha_ctx_ff[HORNER_STEPS-1].dx * ha_acc_ff[HORNER_STEPS-1];
         mp_py_ff  <= ha_ctx_ff[HORNER_STEPS-1].dy * ha_acc_ff[HORNER_STEPS-1];
         xp_ctx_ff <= mp_ctx_ff;
         xp_x_ff   <= xp_x_in;
         xp_y_ff   <= xp_y_in;
         bd_ctx_ff <= xp_ctx_ff;
         bd_out_ff <= bd_out_in;
         bd_fx_ff  <= xp_x_ff[FRAC_BITS-1:0];
         bd_fy_ff  <= xp_y_ff[FRAC_BITS-1:0];
         bd_l0_ff  <= left[0];
         bd_d0_ff  <= down[0];
         for (int b = 0; b < NUM_BANKS; b++) begin
            bd_addr_ff[b] <= bd_addr_in[b];
         end
         rd_wr_ff  <= bd_ctx_ff.wr;
         rd_out_ff <= bd_out_ff;
         rd_fx_ff  <= bd_fx_ff;
         rd_fy_ff  <= bd_fy_ff;
         rd_l0_ff  <= bd_l0_ff;
         rd_d0_ff  <= bd_d0_ff;
         i1_h0_ff  <= H_BITS'(p00 * wfx0) + H_BITS'(p01 * wfx1);
         i1_h1_ff  <= H_BITS'(p10 * wfx0) + H_BITS'(p11 * wfx1);
         i1_fy_ff  <= rd_fy_ff;
         i1_out_ff <= rd_out_ff;
         i2_t0_ff  <= T_BITS'(i1_h0_ff * wfy0);
         i2_t1_ff  <= T_BITS'(i1_h1_ff * wfy1);
         i2_out_ff <= i1_out_ff;
         out_value_ff   <= i2_out_ff ? '0 : val;
         out_outside_ff <= i2_out_ff;
      end
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_out_value == '0)
      else $error("outside result with nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_v_ff && rsp_stall))
      else $error("input stalled without a held result");

   assert property (@(posedge clock) disable iff (reset)
      en && bd_v_ff && !bd_ctx_ff.wr |=> rd_v_ff && !rd_wr_ff)
      else $error("compute item lost at frame store read");

   assert property (@(posedge clock) disable iff (reset)
      $countones(bank_we) <= 1 && (bank_we == '0 || bd_ctx_ff.wr))
      else $error("bad frame store write enable");

endmodule
`default_nettype wire

// ----- tb/radial_distortion_bilinear_remap_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_distortion_bilinear_remap_tb
// Self-checking bench for the radial distortion remap. A scoreboard mirrors
// the frame store, the registers and the fixed-point lens mapping, predicts
// each corrected pixel and compares it in order with what the block returns.
// Source pixels are written before any compute transfer reads them. Register
// settings change between drained phases, under bursty requests and stalls.
// ----------------------------------------------------------------------------
module radial_distortion_bilinear_remap_tb;
   import rdbr_pkg::*;

   localparam longint CYCLE_LIMIT = 1500000;
   localparam int     DRAIN_CYCLES = 60;

   typedef struct {
      bit [PIX_BITS-1:0] value;
      bit                outside;
   } remap_result_type;

   class remap_scoreboard;
      bit [PIX_BITS-1:0]    pixels [int];
      bit [DIM_BITS-1:0]    width_reg;
      bit [DIM_BITS-1:0]    height_reg;
      bit [CSR_DATA_BITS-1:0] centre_reg;
      bit [COEF_BITS-1:0]   c_const, c_lin, c_quad, c_cubic, c_quartic;
      remap_result_type     pending [$];
      int                   errors;

      function new();
         width_reg  = 1024;
         height_reg = 1024;
         centre_reg = 48'd35184374185984;
         c_const    = 32'd268435456;
         c_lin      = 0;
         c_quad     = 0;
         c_cubic    = 0;
         c_quartic  = 0;
         errors     = 0;
      endfunction

      function void set_reg(reg_index_type idx, bit [CSR_DATA_BITS-1:0] d);
         case (idx)
            REG_FRAME_WIDTH:   width_reg  = d[DIM_BITS-1:0];
            REG_FRAME_HEIGHT:  height_reg = d[DIM_BITS-1:0];
            REG_OPTICAL_CTR:   centre_reg = d;
            REG_COEFF_CONST:   c_const    = d[31:0];
            REG_COEFF_LIN:     c_lin      = d[31:0];
            REG_COEFF_QUAD:    c_quad     = d[31:0];
            REG_COEFF_CUBIC:   c_cubic    = d[31:0];
            REG_COEFF_QUARTIC: c_quartic  = d[31:0];
            default: ;
         endcase
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned res, bit_v;
         res   = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > v) bit_v >>= 2;
         while (bit_v != 0) begin
            if (v >= res + bit_v) begin
               v   = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v >>= 2;
         end
         return res;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void locate(input bit [COL_BITS-1:0] col, input bit [ROW_BITS-1:0] row,
                           output longint left, output longint down,
                           output longint fx, output longint fy, output bit outside);
         longint cx, cy, dx, dy, s, acc, xp, yp, w, h;
         longint terms [4];
         cx  = longint'(centre_reg[23:0]);
         cy  = longint'(centre_reg[47:24]);
         dx  = (longint'(col) <<< FRAC_BITS) - cx;
         dy  = (longint'(row) <<< FRAC_BITS) - cy;
         s   = longint'(root_floor(dx * dx + dy * dy)) <<< S_SHIFT;
         terms[0] = longint'($signed(c_cubic));
         terms[1] = longint'($signed(c_quad));
         terms[2] = longint'($signed(c_lin));
         terms[3] = longint'($signed(c_const));
         acc = longint'($signed(c_quartic));
         for (int k = 0; k < 4; k++) acc = clip32(((acc * s) >>> QSHIFT) + terms[k]);
         xp   = cx + ((dx * acc) >>> QSHIFT);
         yp   = cy + ((dy * acc) >>> QSHIFT);
         left = xp >>> FRAC_BITS;
         down = yp >>> FRAC_BITS;
         fx   = xp & ((1 << FRAC_BITS) - 1);
         fy   = yp & ((1 << FRAC_BITS) - 1);
         w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
         h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
         outside = (left < 0) || (left + 1 >= w) || (down < 0) || (down + 1 >= h);
      endfunction

      function bit is_written(longint c, longint r);
         return pixels.exists(int'(r * MAX_WIDTH + c));
      endfunction

      function longint pixel_at(longint c, longint r);
         int a;
         a = int'(r * MAX_WIDTH + c);
         return pixels.exists(a) ? longint'(pixels[a]) : 0;
      endfunction

      function void note_request(bit kind, bit [COL_BITS-1:0] col,
                                 bit [ROW_BITS-1:0] row, bit [PIX_BITS-1:0] pix);
         longint left, down, fx, fy, one, total;
         bit out_flag;
         remap_result_type r;
         if (kind == 1'b0) begin
            pixels[int'(row) * MAX_WIDTH + int'(col)] = pix;
            return;
         end
         locate(col, row, left, down, fx, fy, out_flag);
         r.outside = out_flag;
         r.value   = 0;
         if (!out_flag) begin
            one   = 1 << FRAC_BITS;
            total = (pixel_at(left, down) * (one - fx) + pixel_at(left + 1, down) * fx)
                    * (one - fy)
                  + (pixel_at(left, down + 1) * (one - fx)
                    + pixel_at(left + 1, down + 1) * fx) * fy;
            total = total >> (2 * FRAC_BITS);
            r.value = (total > CLAMP_MAX) ? CLAMP_MAX : total[PIX_BITS-1:0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(bit [PIX_BITS-1:0] value, bit outside);
         remap_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%0d outside=%0d", $time, value, outside);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.value !== value) begin
            $display("%0t: out_value expected %0d actual %0d", $time, e.value, value);
            errors++;
         end
         if (e.outside !== outside) begin
            $display("%0t: outside expected %0d actual %0d", $time, e.outside, outside);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_type = 1'b0;
   logic [COL_BITS-1:0]       req_col = '0;
   logic [ROW_BITS-1:0]       req_row = '0;
   logic [PIX_BITS-1:0]       req_pixel_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PIX_BITS-1:0]       rsp_out_value;
   logic                      rsp_outside;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   remap_scoreboard sb = new();
   longint cycle_count = 0;
   int     stall_mode = 0;
   int     burst_left = 0;
   bit     gaps_on = 1'b1;

   radial_distortion_bilinear_remap uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_col(req_col), .req_row(req_row), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_value(rsp_out_value), .rsp_outside(rsp_outside),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[radial_distortion_bilinear_remap] ERROR");
         $finish;
      end else begin
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_value, rsp_outside);
         if (cycle_count % 331 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   task automatic transfer(bit kind, bit [COL_BITS-1:0] col, bit [ROW_BITS-1:0] row,
                           bit [PIX_BITS-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_col      <= col;
      req_row      <= row;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, col, row, pix);
   endtask

   function automatic bit [PIX_BITS-1:0] random_pixel();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return PIX_BITS'($urandom());
      endcase
   endfunction

   // write any missing neighbor first so no unwritten entry is read
   task automatic compute(bit [COL_BITS-1:0] col, bit [ROW_BITS-1:0] row);
      longint left, down, fx, fy;
      bit out_flag;
      sb.locate(col, row, left, down, fx, fy, out_flag);
      if (!out_flag) begin
         for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++)
               if (!sb.is_written(left + i, down + j))
                  transfer(1'b0, COL_BITS'(left + i), ROW_BITS'(down + j), random_pixel());
      end
      transfer(1'b1, col, row, PIX_BITS'($urandom()));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, bit [CSR_DATA_BITS-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, d);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setup(bit [10:0] w, bit [10:0] h, bit [47:0] centre,
                             bit [31:0] k0, bit [31:0] k1, bit [31:0] k2,
                             bit [31:0] k3, bit [31:0] k4);
      csr_write(REG_FRAME_WIDTH, 48'(w));
      csr_write(REG_FRAME_HEIGHT, 48'(h));
      csr_write(REG_OPTICAL_CTR, centre);
      csr_write(REG_COEFF_CONST, 48'(k0));
      csr_write(REG_COEFF_LIN, 48'(k1));
      csr_write(REG_COEFF_QUAD, 48'(k2));
      csr_write(REG_COEFF_CUBIC, 48'(k3));
      csr_write(REG_COEFF_QUARTIC, 48'(k4));
   endtask

   function automatic bit [31:0] small_coeff(int span);
      return 32'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic random_setup();
      bit [10:0] w, h;
      bit [23:0] cx, cy;
      bit [31:0] k [5];
      w  = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(2, 48));
      h  = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(2, 48));
      cx = 24'($urandom_range(0, w * 4096));
      cy = 24'($urandom_range(0, h * 4096));
      k[0] = 32'd268435456 + small_coeff(1 << 25);
      for (int i = 1; i < 5; i++) k[i] = small_coeff(1 << (26 - 2 * i));
      if ($urandom_range(0, 5) == 0)
         for (int i = 0; i < 5; i++) k[i] = $urandom();
      load_setup(w, h, {cy, cx}, k[0], k[1], k[2], k[3], k[4]);
   endtask

   task automatic random_items(int count);
      int w, h;
      w = (sb.width_reg > MAX_WIDTH) ? MAX_WIDTH : sb.width_reg;
      h = (sb.height_reg > MAX_HEIGHT) ? MAX_HEIGHT : sb.height_reg;
      if (w < 1) w = 1;
      if (h < 1) h = 1;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0:       compute(COL_BITS'($urandom()), ROW_BITS'($urandom()));
            1, 2:    transfer(1'b0, COL_BITS'($urandom_range(0, w - 1)),
                              ROW_BITS'($urandom_range(0, h - 1)), random_pixel());
            default: compute(COL_BITS'($urandom_range(0, w - 1)),
                             ROW_BITS'($urandom_range(0, h - 1)));
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity mapping with default registers
      transfer(1'b0, 0, 0, 16'hFFFF);
      transfer(1'b0, 1, 0, 16'h0000);
      transfer(1'b0, 0, 1, 16'hFFFF);
      transfer(1'b0, 1, 1, 16'h0000);
      compute(0, 0);
      compute(1023, 1023);
      compute(1022, 1022);
      compute(512, 512);
      drain();
      // fractional weights, clamp at full scale, saturated coefficients
      load_setup(11'd16, 11'd16, {24'd32768, 24'd32768}, 32'd201326592, 32'd16777216,
                 32'd0, 32'd0, 32'd0);
      for (int i = 0; i < 6; i++)
         compute(COL_BITS'($urandom_range(0, 15)), ROW_BITS'($urandom_range(0, 15)));
      compute(1023, 0);
      drain();
      load_setup(11'd0, 11'd2047, 48'hFFFF_FFFF_FFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      compute(0, 0);
      compute(1023, 1023);
      drain();
      load_setup(11'd2047, 11'd1, 48'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000);
      compute(5, 0);
      compute(1023, 1023);
      drain();
      load_setup(11'd2047, 11'd2047, {24'hFFFFFF, 24'hFFFFFF}, 32'd268435456, 0, 0, 0, 0);
      compute(1022, 1022);
      compute(3, 700);
      drain();

      for (int p = 0; p < 10; p++) begin
         gaps_on = (p % 3 != 1);
         random_setup();
         random_items(25);
         if (p == 4) drain();
         random_items(25);
         drain();
      end

      if (sb.errors == 0) begin
         $display("[radial_distortion_bilinear_remap] OK");
      end else begin
         $display("[radial_distortion_bilinear_remap] ERROR");
      end
      $finish;
   end

endmodule
